// ===== hw/rtl/aes_ige_block_chainer_unit_macros.svh =====
// Assertion macros for the checker file, aig_checker.
`ifndef AES_IGE_BLOCK_CHAINER_UNIT_MACROS_SVH
`define AES_IGE_BLOCK_CHAINER_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define AIG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AIG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/aig_pkg.sv =====
// ----------------------------------------------------------------------------
// aig_pkg
// Shared types, codes and AES helper functions for the IGE chaining block.
// ----------------------------------------------------------------------------
package aig_pkg;
    localparam int RK_DEPTH = 30;
    localparam int RK_AW = 5;

    typedef enum logic [1:0] {
        MODE_DATA = 2'd0,
        MODE_IV_C = 2'd1,
        MODE_IV_M = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CFG_KEY0 = 3'd0,
        CFG_KEY1 = 3'd1,
        CFG_KEY2 = 3'd2,
        CFG_KEY3 = 3'd3,
        CFG_KLEN = 3'd4,
        CFG_DIR  = 3'd5
    } t_cfg_idx;

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xt(x);
        end
        return p;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // State byte i sits at bits [127-8i -: 8]; column c holds bytes 4c..4c+3.
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [127:0] t;
        logic [127:0] u;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(4*c+r) -: 8] = sbox(s[127-8*(4*((c+r)%4)+r) -: 8]);
            end
        end
        u = t;
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[127-32*c -: 8];
                a1 = t[119-32*c -: 8];
                a2 = t[111-32*c -: 8];
                a3 = t[103-32*c -: 8];
                u[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                u[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                u[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                u[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        return u;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] u;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127-32*c -: 8];
            a1 = s[119-32*c -: 8];
            a2 = s[111-32*c -: 8];
            a3 = s[103-32*c -: 8];
            u[127-32*c -: 8] = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
            u[119-32*c -: 8] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13);
            u[111-32*c -: 8] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11);
            u[103-32*c -: 8] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14);
        end
        return u;
    endfunction

    // Inverse shift rows and inverse substitution.
    function automatic logic [127:0] dec_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(4*((c+r)%4)+r) -: 8] = inv_sbox(s[127-8*(4*c+r) -: 8]);
            end
        end
        return t;
    endfunction
endpackage

// ===== hw/rtl/aes_ige_block_chainer_unit.sv =====
// ----------------------------------------------------------------------------
// aes_ige_block_chainer_unit
// AES block cipher in IGE chaining mode with an internal round-key memory.
// ----------------------------------------------------------------------------
// A first-half IV transfer (mode 1) loads the cipher chain and expands the
// round keys into a 30 x 64 bit memory with one write and one read port, one
// key-schedule word per cycle: the input stays busy while 44, 52 or 60 words
// are written for 128, 192 or 256 bit keys, the first Nk of them copying the
// key words themselves. A second-half IV transfer (mode 2) loads the other
// chain value without leaving the idle state, and a mode 3 transfer is
// dropped at once. A data block is accepted only in the idle state: S_RD
// issues the first key read, each of the Nr + 1 round keys (the whitening key
// included) is read as two halves because the memory returns one 64-bit half
// per cycle, S_FIN does the final chaining into the output register, and the
// input is taken again in the idle state after that. The next block waits for
// the chain values of this one. The output register parts the two sides: a
// new transfer is taken while a result waits, and only the final chaining
// step of the next block stalls until the waiting result has been taken. Key,
// key length and direction writes belong between blocks; key changes take
// effect at the next first-half IV transfer.
module aes_ige_block_chainer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_block_hi,
    input  logic [63:0] i_block_lo,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_hi,
    output logic [63:0] o_result_lo
);
    import aig_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_KEXP  = 6'b000010,
        S_KEXP2 = 6'b000100,
        S_RD    = 6'b001000,
        S_RND   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    // Key, key length and direction registers.
    logic [63:0] r_key [4];
    logic [1:0]  r_klen;
    logic        r_dir;
    // Chain values.
    logic [127:0] r_cc, r_pc;
    // Round-key memory with a registered read.
    logic [63:0] r_rk [RK_DEPTH];
    logic [63:0] r_rk_q;
    logic        rk_we;
    logic [RK_AW-1:0] rk_wa, rk_ra;
    logic [63:0] rk_wd;

    t_state r_st, n_st;
    logic [3:0] r_nr;
    logic [3:0] r_nk;          // key words, 4, 6 or 8
    logic [5:0] r_wi;          // key schedule word index
    logic [255:0] r_win;       // sliding window of the last nk words, newest low
    logic [7:0] r_rcon;
    logic [31:0] r_wprev;      // even word waiting for its odd partner
    logic [3:0] r_mod;         // wi mod nk

    logic [127:0] r_s;         // cipher state
    logic [127:0] r_blk;       // input block, for the chain update
    logic [3:0]  r_rnd;        // round being keyed
    logic        r_half;       // set once the high key half is held
    logic [63:0] r_khi;
    logic        r_first;      // whitening round pending
    logic        r_ovalid;
    logic [127:0] r_res;

    logic last_rnd;
    logic fin_go;

    assign last_rnd = (r_rnd == r_nr);
    // The final chaining step waits while the output register is full and not being read.
    assign fin_go = (r_st == S_FIN) && (!r_ovalid || i_ready);

    assign o_cfg_ready = 1'b1;
    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_result_hi = r_res[127:64];
    assign o_result_lo = r_res[63:0];

    // Word j of the initial key window (window is right-aligned, word 0 high).
    function automatic logic [31:0] word_at(input logic [255:0] w, input logic [3:0] nk,
                                            input logic [3:0] j);
        logic [3:0] pos;
        pos = nk - 4'd1 - j;
        return w[{pos[2:0], 5'd0} +: 32];
    endfunction

    always_ff @(posedge i_clk) begin
        if (rk_we) r_rk[rk_wa] <= rk_wd;
        r_rk_q <= r_rk[rk_ra];
    end

    // Key schedule step for word wi.
    logic [31:0] ks_prev, ks_t, ks_new;
    logic [3:0]  nk_eff;
    logic [5:0]  ks_total;
    always_comb begin
        ks_prev = r_win[31:0];
        ks_t = ks_prev;
        if (r_mod == 4'd0) begin
            ks_t = sub_word({ks_prev[23:0], ks_prev[31:24]}) ^ {r_rcon, 24'h0};
        end else if (r_nk == 4'd8 && r_mod == 4'd4) begin
            ks_t = sub_word(ks_prev);
        end
        case (r_nk)
            4'd4:    ks_new = r_win[127:96] ^ ks_t;
            4'd6:    ks_new = r_win[191:160] ^ ks_t;
            default: ks_new = r_win[255:224] ^ ks_t;
        endcase
        ks_total = {r_nr, 2'b00} + 6'd4;
        case (r_klen)
            2'd0:    nk_eff = 4'd4;
            2'd1:    nk_eff = 4'd6;
            default: nk_eff = 4'd8;
        endcase
    end

    // Round key read address, issued in the cycle before its data is used: the
    // high half is requested in the cycle before a round starts and the low half
    // while r_half is clear, while the cycle with r_half set already requests
    // the high half of the next round. Encrypt walks up, decrypt walks down.
    logic [3:0] addr_rnd;
    logic [3:0] key_round;
    logic       rd_lo;
    assign addr_rnd = (r_st == S_RND && r_half && !last_rnd) ? r_rnd + 4'd1 : r_rnd;
    assign key_round = r_dir ? (r_nr - addr_rnd) : addr_rnd;
    assign rd_lo = (r_st == S_RND) && !r_half;
    always_comb begin
        rk_ra = RK_AW'({key_round, rd_lo});
        rk_we = 1'b0;
        rk_wa = RK_AW'(r_wi[5:1]);
        rk_wd = {r_wprev, ks_new};
        if (r_st == S_KEXP2) begin
            rk_we = r_wi[0];
            rk_wd = {r_wprev, word_at(r_win, r_nk, r_wi[3:0])};
            rk_wa = RK_AW'(r_wi[5:1]);
        end else if (r_st == S_KEXP) begin
            rk_we = r_wi[0];
        end
    end

    logic [127:0] rkey;
    logic [127:0] enc_nx, dec_nx;
    assign rkey = {r_khi, r_rk_q};
    always_comb begin
        enc_nx = enc_round(r_s, last_rnd) ^ rkey;
        dec_nx = dec_sub_shift(r_s) ^ rkey;
        if (!last_rnd) dec_nx = inv_mix(dec_nx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ovalid <= 1'b0;
            r_klen <= 2'd0;
            r_dir <= 1'b0;
            r_nr <= 4'd10;
            r_cc <= '0;
            r_pc <= '0;
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_KEY0: r_key[0] <= i_cfg_data;
                    CFG_KEY1: r_key[1] <= i_cfg_data;
                    CFG_KEY2: r_key[2] <= i_cfg_data;
                    CFG_KEY3: r_key[3] <= i_cfg_data;
                    CFG_KLEN: r_klen <= i_cfg_data[1:0];
                    CFG_DIR:  r_dir <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (fin_go) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            r_st <= n_st;
            case (r_st)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        case (i_mode)
                            MODE_IV_C: begin
                                r_cc <= {i_block_hi, i_block_lo};
                                r_nk <= nk_eff;
                                r_nr <= nk_eff + 4'd6;
                                r_win <= {r_key[0], r_key[1], r_key[2], r_key[3]}
                                         >> (9'd32 * (9'd8 - {5'd0, nk_eff}));
                                r_wi <= 6'd0;
                                r_rcon <= 8'h01;
                            end
                            MODE_IV_M: r_pc <= {i_block_hi, i_block_lo};
                            MODE_DATA: begin
                                r_blk <= {i_block_hi, i_block_lo};
                                r_s <= {i_block_hi, i_block_lo} ^ (r_dir ? r_pc : r_cc);
                                r_rnd <= 4'd0;
                                r_half <= 1'b0;
                                r_first <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                // Write the key words themselves, one per cycle; the window
                // stays in place and each word is picked out by its index.
                S_KEXP2: begin
                    if (!r_wi[0]) r_wprev <= word_at(r_win, r_nk, r_wi[3:0]);
                    r_wi <= r_wi + 6'd1;
                    if (r_wi + 6'd1 == {2'b00, r_nk}) r_mod <= 4'd0;
                end
                S_KEXP: begin
                    if (!r_wi[0]) r_wprev <= ks_new;
                    r_win <= {r_win[223:0], ks_new};
                    if (r_mod == 4'd0) r_rcon <= xt(r_rcon);
                    r_mod <= (r_mod + 4'd1 == r_nk) ? 4'd0 : r_mod + 4'd1;
                    r_wi <= r_wi + 6'd1;
                end
                S_RND: begin
                    if (!r_half) begin
                        r_khi <= r_rk_q;
                        r_half <= 1'b1;
                    end else begin
                        if (r_first) r_s <= r_s ^ rkey;
                        else if (r_dir) r_s <= dec_nx;
                        else r_s <= enc_nx;
                        r_first <= 1'b0;
                        if (!last_rnd) r_rnd <= r_rnd + 4'd1;
                        r_half <= 1'b0;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        if (r_dir) begin
                            r_res <= r_s ^ r_cc;
                            r_pc <= r_s ^ r_cc;
                            r_cc <= r_blk;
                        end else begin
                            r_res <= r_s ^ r_pc;
                            r_cc <= r_s ^ r_pc;
                            r_pc <= r_blk;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    case (i_mode)
                        MODE_IV_C: n_st = S_KEXP2;
                        MODE_DATA: n_st = S_RD;
                        default:   n_st = S_IDLE;
                    endcase
                end
            end
            S_KEXP2: if (r_wi + 6'd1 == {2'b00, r_nk}) n_st = S_KEXP;
            S_KEXP:  if (r_wi + 6'd1 == ks_total) n_st = S_IDLE;
            S_RD:    n_st = S_RND;
            S_RND:   if (r_half && last_rnd) n_st = S_FIN;
            S_FIN:   if (fin_go) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/aig_checker.sv =====
// ----------------------------------------------------------------------------
// aig_checker
// Port-level checks on the IGE chaining block, bound to the top level.
// ----------------------------------------------------------------------------
`include "aes_ige_block_chainer_unit_macros.svh"
module aig_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [1:0]  i_mode,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_result_hi,
    input logic [63:0] o_result_lo
);
    import aig_pkg::*;
    logic         in_xfer;
    logic [127:0] res;
    assign in_xfer = i_valid && o_ready;
    assign res = {o_result_hi, o_result_lo};
    // A waiting result holds its value.
    `AIG_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(res))
    // An IV or ignored transfer never raises a result right after.
    `AIG_ASSERT_NEXT(a_iv, i_clk, i_rst_n, in_xfer && i_mode != MODE_DATA, !$rose(o_valid))
    // A second IV half or an ignored transfer leaves the input free.
    `AIG_ASSERT_NEXT(a_drop, i_clk, i_rst_n, in_xfer && i_mode[1], o_ready)
    // A data block cannot finish in the next cycle and keeps the input busy.
    `AIG_ASSERT_NEXT(a_lat, i_clk, i_rst_n, in_xfer && i_mode == MODE_DATA, !o_ready && !$rose(o_valid))
endmodule

bind aes_ige_block_chainer_unit aig_checker u_aig_checker (.*);
